[hw/rtl/rbpd_pkg.sv]
package rbpd_pkg;

	// Container store geometry
	localparam int MAX_CONTAINERS = 4096;
	localparam int META_AW        = $clog2(MAX_CONTAINERS);
	localparam int RF_AW          = META_AW - 3;

	// Format constants
	localparam logic [31:0] COOKIE_NO_RUN   = 32'd12346;
	localparam logic [15:0] COOKIE_RUN      = 16'd12347;
	localparam logic [15:0] ARRAY_MAX_M1    = 16'd4095;
	localparam logic [18:0] BITSET_BYTES    = 19'd8192;
	localparam logic [16:0] NO_OFFSET_LIMIT = 17'd4;
	localparam logic [16:0] MAX_CONT_17     = 17'(MAX_CONTAINERS);

	// Configuration reset values and indexes
	localparam logic [19:0] GROUP_COUNT_RESET = 20'd1000000;
	localparam logic [31:0] GROUP_KEY_RESET   = 32'h7FFF_FFFF;
	localparam logic CFG_GROUP_COUNT = 1'b0;
	localparam logic CFG_GROUP_KEY   = 1'b1;

	// Error codes
	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_COOKIE    = 3'd1;
	localparam logic [2:0] ERR_TRUNC     = 3'd2;
	localparam logic [2:0] ERR_GCOUNT    = 3'd3;
	localparam logic [2:0] ERR_GKEY      = 3'd4;
	localparam logic [2:0] ERR_CONTAINER = 3'd5;

	typedef enum logic [4:0] {
		PH_HEAD,
		PH_GCOUNT,
		PH_GKEY,
		PH_COOKIE,
		PH_COUNT,
		PH_RUNFLAGS,
		PH_META,
		PH_OFFSETS,
		PH_NRUNS,
		PH_RUN,
		PH_ARRAY,
		PH_BITSET,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_BITS,
		E_OPEN,
		E_OPEN2,
		E_FIN
	} eng_t;

	typedef struct packed {
		logic [62:0] first;
		logic [62:0] last;
		logic [2:0]  err;
		logic        done;
		logic        last_step;
	} result_t;

	// Index of the lowest set bit of a byte
	function automatic logic [2:0] lowest_bit(input logic [7:0] m);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (m[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	// Position from group key, container key and low half, masked to 63 bits
	function automatic logic [62:0] make_pos(input logic [31:0] ghk, input logic [15:0] key,
		input logic [15:0] low);
		return {ghk[30:0], key, low};
	endfunction

endpackage

[hw/rtl/roaring_bitmap_position_decoder.sv]
// Roaring bitmap position decoder.
// Input channel (in_valid/in_ready): one byte of a serialized bitmap per transfer,
// with final_byte on the last byte of the blob. Output channel (out_valid/out_ready):
// one range per transfer (first == last for single positions), plus a marker with
// decode_done and error_code when the blob completes or fails. last_of_step flags
// the final result caused by one input byte.
// Config port: cfg_we with cfg_index 0 (group count limit) or 1 (group key limit).
// Throughput: one byte per cycle for header, metadata and skipped bytes while the engine
// is not stalled; a byte that opens a container is followed by a read of the container
// store and then the decision; a bitset byte gives one result per set bit, lowest first.
// Results pass through a pending slot and a two-entry output queue. The engine stalls
// while the pending slot is occupied and the output queue is full, and in_ready is low
// while the one-entry input buffer is occupied and is not being emptied.
// Reset puts the parser in format detect with default limits; the container store
// needs no clearing since only entries written for the current bitmap are read.
module roaring_bitmap_position_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [62:0] first_position,
	output logic [62:0] last_position,
	output logic [2:0]  error_code,
	output logic        decode_done,
	output logic        last_of_step,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	// Configuration
	logic [19:0] gcl_q;
	logic [31:0] gkl_q;

	// Parser state
	rbpd_pkg::phase_t phase_q, n_phase;
	logic [63:0] fa_q, n_fa;
	logic [3:0]  fbc_q, n_fbc;
	logic        wide_q, n_wide;
	logic [19:0] groups_q, n_groups;
	logic [31:0] ghk_q, n_ghk;
	logic [16:0] total_q, n_total;
	logic [16:0] idx_q, n_idx;
	logic        runs_q, n_runs;
	logic [16:0] items_q, n_items;
	logic [18:0] skip_q, n_skip;

	// Engine state
	rbpd_pkg::eng_t est_q, n_est;
	logic        fin_q, n_fin;
	logic        openp_q, n_openp;
	logic [7:0]  mask_q, n_mask;
	logic [12:0] off_q, n_off;
	logic [15:0] key_q, n_key;

	// Input buffer
	logic        buf_v_q;
	logic [7:0]  buf_b_q;
	logic        buf_f_q;
	logic        buf_pop;

	// Container store
	logic [31:0] meta_mem [rbpd_pkg::MAX_CONTAINERS];
	logic [7:0]  rf_mem [rbpd_pkg::MAX_CONTAINERS / 8];
	logic [31:0] rd_meta_q;
	logic [7:0]  rd_rf_q;
	logic        mw_meta, mw_rf;
	logic [31:0] meta_wd;

	// Result path
	rbpd_pkg::result_t pend_q, em;
	logic        pend_v_q;
	logic        em_v, step_end;
	rbpd_pkg::result_t fifo_q [2];
	logic [1:0]  cnt_q;
	logic        wp_q, rp_q;
	logic        full, push, pop, eng_ok;

	assign full     = (cnt_q == 2'd2);
	assign pop      = out_valid && out_ready;
	assign eng_ok   = !pend_v_q || !full;
	assign push     = pend_v_q && !full && (em_v || pend_q.last_step);
	assign in_ready = !buf_v_q || buf_pop;

	// Parser and engine next state
	always_comb begin
		logic [7:0]  b;
		logic        fin;
		logic [63:0] gv;
		logic [3:0]  gc;
		logic [31:0] cv;
		logic        do_cookie, do_fail, do_finish, do_open, do_tail, tail_fin, emitted;
		logic [2:0]  fail_code;
		logic [16:0] stop;
		logic [16:0] tot;
		logic [12:0] off;
		logic [19:0] gdec;
		logic [7:0]  rest;
		logic [2:0]  bi;

		n_phase = phase_q; n_fa = fa_q; n_fbc = fbc_q; n_wide = wide_q;
		n_groups = groups_q; n_ghk = ghk_q; n_total = total_q; n_idx = idx_q;
		n_runs = runs_q; n_items = items_q; n_skip = skip_q;
		n_est = est_q; n_fin = fin_q; n_openp = openp_q; n_mask = mask_q;
		n_off = off_q; n_key = key_q;
		buf_pop = 1'b0; mw_meta = 1'b0; mw_rf = 1'b0; meta_wd = '0;
		em_v = 1'b0; em = '0; step_end = 1'b0;
		b = buf_b_q; fin = buf_f_q;
		gv = fa_q | ({56'd0, buf_b_q} << {fbc_q[2:0], 3'b000});
		gc = fbc_q + 4'd1;
		cv = '0; do_cookie = 1'b0; do_fail = 1'b0; do_finish = 1'b0; do_open = 1'b0;
		do_tail = 1'b0; tail_fin = 1'b0; emitted = 1'b0; fail_code = rbpd_pkg::ERR_OK;
		stop = '0; tot = '0;
		off = 13'(~skip_q[12:0] + 13'd1);
		gdec = '0; rest = '0; bi = '0;

		case (est_q)
			rbpd_pkg::E_IDLE: begin
				if (eng_ok && buf_v_q) begin
					buf_pop = 1'b1;
					case (phase_q)
						rbpd_pkg::PH_HEAD: begin
							if (gc >= 4'd4) begin
								if (gv[31:0] == rbpd_pkg::COOKIE_NO_RUN ||
									gv[15:0] == rbpd_pkg::COOKIE_RUN) begin
									n_fa = '0; n_fbc = '0; n_wide = 1'b0; n_ghk = '0;
									do_cookie = 1'b1; cv = gv[31:0];
								end else begin
									n_fa = gv; n_fbc = gc; n_wide = 1'b1;
									n_phase = rbpd_pkg::PH_GCOUNT;
								end
							end else begin
								n_fa = gv; n_fbc = gc;
							end
						end
						rbpd_pkg::PH_GCOUNT: begin
							if (gc >= 4'd8) begin
								n_fa = '0; n_fbc = '0;
								if (gv > {44'd0, gcl_q}) begin
									do_fail = 1'b1; fail_code = rbpd_pkg::ERR_GCOUNT;
								end else if (gv == 64'd0) begin
									em_v = 1'b1; em.done = 1'b1; emitted = 1'b1;
									n_phase = rbpd_pkg::PH_DRAIN;
								end else begin
									n_groups = gv[19:0]; n_phase = rbpd_pkg::PH_GKEY;
								end
							end else begin
								n_fa = gv; n_fbc = gc;
							end
						end
						rbpd_pkg::PH_GKEY: begin
							if (gc >= 4'd4) begin
								n_fa = '0; n_fbc = '0;
								if (gv > {32'd0, gkl_q}) begin
									do_fail = 1'b1; fail_code = rbpd_pkg::ERR_GKEY;
								end else begin
									n_ghk = gv[31:0]; n_phase = rbpd_pkg::PH_COOKIE;
								end
							end else begin
								n_fa = gv; n_fbc = gc;
							end
						end
						rbpd_pkg::PH_COOKIE: begin
							if (gc >= 4'd4) begin
								n_fa = '0; n_fbc = '0; do_cookie = 1'b1; cv = gv[31:0];
							end else begin
								n_fa = gv; n_fbc = gc;
							end
						end
						rbpd_pkg::PH_COUNT: begin
							if (gc >= 4'd4) begin
								n_fa = '0; n_fbc = '0;
								if (gv[31:0] > 32'(rbpd_pkg::MAX_CONTAINERS)) begin
									do_fail = 1'b1; fail_code = rbpd_pkg::ERR_CONTAINER;
								end else begin
									n_total = gv[16:0]; n_idx = '0;
									if (gv[16:0] == 17'd0) begin
										do_finish = 1'b1;
									end else begin
										n_phase = rbpd_pkg::PH_META;
									end
								end
							end else begin
								n_fa = gv; n_fbc = gc;
							end
						end
						rbpd_pkg::PH_RUNFLAGS: begin
							mw_rf = 1'b1;
							n_idx = idx_q + 17'd8;
							n_items = (items_q != 17'd0) ? items_q - 17'd1 : items_q;
							if (n_items == 17'd0) begin
								n_idx = '0; n_phase = rbpd_pkg::PH_META;
							end
						end
						rbpd_pkg::PH_META: begin
							if (gc >= 4'd4) begin
								n_fa = '0; n_fbc = '0;
								mw_meta = (idx_q < rbpd_pkg::MAX_CONT_17);
								meta_wd = gv[31:0];
								n_idx = idx_q + 17'd1;
								if (n_idx >= total_q) begin
									if (!runs_q || total_q >= rbpd_pkg::NO_OFFSET_LIMIT) begin
										n_skip = {total_q, 2'b00};
										n_phase = rbpd_pkg::PH_OFFSETS;
									end else begin
										n_idx = '0; do_open = 1'b1;
									end
								end
							end else begin
								n_fa = gv; n_fbc = gc;
							end
						end
						rbpd_pkg::PH_OFFSETS: begin
							n_skip = (skip_q != 19'd0) ? skip_q - 19'd1 : skip_q;
							if (n_skip == 19'd0) begin
								n_idx = '0; do_open = 1'b1;
							end
						end
						rbpd_pkg::PH_NRUNS: begin
							if (gc >= 4'd2) begin
								n_fa = '0; n_fbc = '0;
								n_items = {1'b0, gv[15:0]};
								if (gv[15:0] == 16'd0) begin
									n_idx = idx_q + 17'd1; do_open = 1'b1;
								end else begin
									n_phase = rbpd_pkg::PH_RUN;
								end
							end else begin
								n_fa = gv; n_fbc = gc;
							end
						end
						rbpd_pkg::PH_RUN: begin
							if (gc >= 4'd4) begin
								n_fa = '0; n_fbc = '0;
								stop = {1'b0, gv[15:0]} + {1'b0, gv[31:16]};
								em_v = 1'b1; emitted = 1'b1;
								em.first = rbpd_pkg::make_pos(ghk_q, key_q, gv[15:0]);
								em.last = rbpd_pkg::make_pos(ghk_q, key_q,
									stop[16] ? 16'hFFFF : stop[15:0]);
								n_items = (items_q != 17'd0) ? items_q - 17'd1 : items_q;
								if (n_items == 17'd0) begin
									n_idx = idx_q + 17'd1; do_open = 1'b1;
								end
							end else begin
								n_fa = gv; n_fbc = gc;
							end
						end
						rbpd_pkg::PH_ARRAY: begin
							if (gc >= 4'd2) begin
								n_fa = '0; n_fbc = '0;
								em_v = 1'b1; emitted = 1'b1;
								em.first = rbpd_pkg::make_pos(ghk_q, key_q, gv[15:0]);
								em.last = em.first;
								n_items = (items_q != 17'd0) ? items_q - 17'd1 : items_q;
								if (n_items == 17'd0) begin
									n_idx = idx_q + 17'd1; do_open = 1'b1;
								end
							end else begin
								n_fa = gv; n_fbc = gc;
							end
						end
						rbpd_pkg::PH_BITSET: begin
							// first set bit now, the rest one per cycle while the engine is not stalled
							if (b != 8'd0) begin
								bi = rbpd_pkg::lowest_bit(b);
								em_v = 1'b1; emitted = 1'b1;
								em.first = rbpd_pkg::make_pos(ghk_q, key_q, {off, bi});
								em.last = em.first;
								rest = b & (b - 8'd1);
							end
							n_off = off; n_mask = rest;
							n_skip = (skip_q != 19'd0) ? skip_q - 19'd1 : skip_q;
							if (n_skip == 19'd0) begin
								n_idx = idx_q + 17'd1; do_open = 1'b1;
							end
						end
						rbpd_pkg::PH_DRAIN: begin
						end
						default: begin
							n_phase = rbpd_pkg::PH_DRAIN;
						end
					endcase
					if (rest != 8'd0) begin
						n_est = rbpd_pkg::E_BITS; n_fin = fin; n_openp = do_open;
					end else if (do_open) begin
						n_est = rbpd_pkg::E_OPEN; n_fin = fin;
					end else begin
						do_tail = 1'b1; tail_fin = fin;
					end
				end
			end
			rbpd_pkg::E_BITS: begin
				if (eng_ok) begin
					bi = rbpd_pkg::lowest_bit(mask_q);
					em_v = 1'b1; emitted = 1'b1;
					em.first = rbpd_pkg::make_pos(ghk_q, key_q, {off_q, bi});
					em.last = em.first;
					n_mask = mask_q & (mask_q - 8'd1);
					if (n_mask == 8'd0) begin
						if (openp_q) begin
							n_est = rbpd_pkg::E_OPEN;
						end else begin
							do_tail = 1'b1; tail_fin = fin_q;
						end
					end
				end
			end
			rbpd_pkg::E_OPEN: begin
				// store read at idx_q is in flight
				n_est = rbpd_pkg::E_OPEN2;
			end
			rbpd_pkg::E_OPEN2: begin
				if (eng_ok) begin
					if (idx_q >= total_q || idx_q >= rbpd_pkg::MAX_CONT_17) begin
						do_finish = 1'b1;
					end else begin
						n_key = rd_meta_q[15:0];
						if (runs_q && rd_rf_q[idx_q[2:0]]) begin
							n_phase = rbpd_pkg::PH_NRUNS;
						end else if (rd_meta_q[31:16] <= rbpd_pkg::ARRAY_MAX_M1) begin
							n_items = {1'b0, rd_meta_q[31:16]} + 17'd1;
							n_phase = rbpd_pkg::PH_ARRAY;
						end else begin
							n_skip = rbpd_pkg::BITSET_BYTES;
							n_phase = rbpd_pkg::PH_BITSET;
						end
					end
					do_tail = 1'b1; tail_fin = fin_q;
				end
			end
			rbpd_pkg::E_FIN: begin
				if (eng_ok) begin
					em_v = 1'b1; emitted = 1'b1;
					em.err = rbpd_pkg::ERR_TRUNC; em.done = 1'b1;
					do_tail = 1'b1; tail_fin = 1'b1;
					n_phase = rbpd_pkg::PH_DRAIN;
				end
			end
			default: begin
				n_est = rbpd_pkg::E_IDLE;
			end
		endcase

		// Cookie word of a 32-bit bitmap
		if (do_cookie) begin
			if (cv[15:0] == rbpd_pkg::COOKIE_RUN) begin
				n_runs = 1'b1;
				tot = {1'b0, cv[31:16]} + 17'd1;
				n_total = tot;
				if (tot > rbpd_pkg::MAX_CONT_17) begin
					do_fail = 1'b1; fail_code = rbpd_pkg::ERR_CONTAINER;
				end else begin
					n_items = (tot + 17'd7) >> 3;
					n_idx = '0;
					n_phase = rbpd_pkg::PH_RUNFLAGS;
				end
			end else if (cv == rbpd_pkg::COOKIE_NO_RUN) begin
				n_runs = 1'b0; n_phase = rbpd_pkg::PH_COUNT;
			end else begin
				do_fail = 1'b1; fail_code = rbpd_pkg::ERR_COOKIE;
			end
		end

		// Error marker
		if (do_fail) begin
			em_v = 1'b1; emitted = 1'b1; em = '0;
			em.err = fail_code; em.done = 1'b1;
			n_phase = rbpd_pkg::PH_DRAIN;
		end

		// End of one bitmap: next group or completion marker
		if (do_finish) begin
			if (wide_q) begin
				gdec = (groups_q != 20'd0) ? groups_q - 20'd1 : groups_q;
				n_groups = gdec;
			end
			if (wide_q && gdec != 20'd0) begin
				n_phase = rbpd_pkg::PH_GKEY;
			end else begin
				em_v = 1'b1; emitted = 1'b1; em = '0; em.done = 1'b1;
				n_phase = rbpd_pkg::PH_DRAIN;
			end
		end

		// End of step: truncation check and new blob on the final byte
		if (do_tail) begin
			if (tail_fin && n_phase != rbpd_pkg::PH_DRAIN && emitted) begin
				n_est = rbpd_pkg::E_FIN; n_fin = 1'b1;
			end else begin
				if (tail_fin && n_phase != rbpd_pkg::PH_DRAIN) begin
					em_v = 1'b1; em = '0;
					em.err = rbpd_pkg::ERR_TRUNC; em.done = 1'b1;
				end
				if (tail_fin) begin
					n_phase = rbpd_pkg::PH_HEAD; n_fa = '0; n_fbc = '0; n_wide = 1'b0;
					n_groups = '0; n_ghk = '0; n_total = '0; n_idx = '0; n_runs = 1'b0;
					n_items = '0; n_skip = '0;
				end
				step_end = 1'b1;
				n_est = rbpd_pkg::E_IDLE;
			end
		end
	end

	// Control and parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcl_q <= rbpd_pkg::GROUP_COUNT_RESET;
			gkl_q <= rbpd_pkg::GROUP_KEY_RESET;
			phase_q <= rbpd_pkg::PH_HEAD;
			fa_q <= '0; fbc_q <= '0; wide_q <= 1'b0; groups_q <= '0; ghk_q <= '0;
			total_q <= '0; idx_q <= '0; runs_q <= 1'b0; items_q <= '0; skip_q <= '0;
			est_q <= rbpd_pkg::E_IDLE; fin_q <= 1'b0; openp_q <= 1'b0;
			buf_v_q <= 1'b0; pend_v_q <= 1'b0;
			cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == rbpd_pkg::CFG_GROUP_COUNT) begin
					gcl_q <= cfg_data[19:0];
				end else begin
					gkl_q <= cfg_data;
				end
			end
			phase_q <= n_phase; fa_q <= n_fa; fbc_q <= n_fbc; wide_q <= n_wide;
			groups_q <= n_groups; ghk_q <= n_ghk; total_q <= n_total; idx_q <= n_idx;
			runs_q <= n_runs; items_q <= n_items; skip_q <= n_skip;
			est_q <= n_est; fin_q <= n_fin; openp_q <= n_openp;
			if (in_valid && in_ready) begin
				buf_v_q <= 1'b1;
			end else if (buf_pop) begin
				buf_v_q <= 1'b0;
			end
			if (em_v) begin
				pend_v_q <= 1'b1;
			end else if (push) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		mask_q <= n_mask; off_q <= n_off; key_q <= n_key;
		if (in_valid && in_ready) begin
			buf_b_q <= data_byte; buf_f_q <= final_byte;
		end
		if (em_v) begin
			pend_q <= em;
			pend_q.last_step <= step_end;
		end else if (step_end) begin
			pend_q.last_step <= 1'b1;
		end
		if (push) begin
			fifo_q[wp_q] <= pend_q;
		end
	end

	// Container store: key and cardinality rows, run flags one byte per eight
	always_ff @(posedge clk) begin
		if (mw_meta) begin
			meta_mem[idx_q[rbpd_pkg::META_AW-1:0]] <= meta_wd;
		end
		if (mw_rf) begin
			rf_mem[idx_q[rbpd_pkg::META_AW-1:3]] <= buf_b_q;
		end
		rd_meta_q <= meta_mem[idx_q[rbpd_pkg::META_AW-1:0]];
		rd_rf_q <= rf_mem[idx_q[rbpd_pkg::META_AW-1:3]];
	end

	// Output queue head
	assign out_valid      = (cnt_q != 2'd0);
	assign first_position = fifo_q[rp_q].first;
	assign last_position  = fifo_q[rp_q].last;
	assign error_code     = fifo_q[rp_q].err;
	assign decode_done    = fifo_q[rp_q].done;
	assign last_of_step   = fifo_q[rp_q].last_step;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		push && pend_q.done |-> pend_q.first == 63'd0 && pend_q.last == 63'd0)
		else $error("marker result carries a position");

	a_open_seq: assert property (@(posedge clk) disable iff (!arst_n)
		est_q == rbpd_pkg::E_OPEN |=> est_q == rbpd_pkg::E_OPEN2)
		else $error("store read not followed by decision");

	a_buf_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !buf_v_q || buf_pop)
		else $error("input buffer overwritten");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		em_v && pend_v_q |-> push)
		else $error("pending result lost");

endmodule
